// ===== hdl/pidl_pkg.sv =====
package pidl_pkg;

  localparam int Depth     = 16;
  localparam int DataWidth = 32;
  localparam int CountW    = $clog2(Depth + 1);
  localparam int IdxW      = $clog2(Depth);
  localparam int ActW      = 3;
  localparam int PosW      = 5;
  localparam int StatW     = 2;
  localparam int OutDataW  = 32;
  localparam int InDataW   = 32;

  typedef enum logic [ActW-1:0] {
    ActInsFront = 3'd0,
    ActInsPos   = 3'd1,
    ActAppend   = 3'd2,
    ActRemove   = 3'd3,
    ActDump     = 3'd4
  } action_e;

  typedef enum logic [StatW-1:0] {
    StatOk   = 2'd0,
    StatFull = 2'd1,
    StatBad  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StateIdle,
    StateExec,
    StateDump
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic commit;
    logic load_dump;
  } pidl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dump;
    logic count_zero;
    logic out_free;
    logic dump_last;
  } pidl_stat_t;

endpackage

// ===== hdl/pidl_if.sv =====
interface pidl_in_if import pidl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ActW-1:0]           action;
  logic [PosW-1:0]           position;
  logic signed [InDataW-1:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink (input valid, action, position, value, output ready);
endinterface

interface pidl_out_if import pidl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OutDataW-1:0] data_out;
  logic [StatW-1:0]           status;
  logic [CountW-1:0]          length;
  logic                       last;

  modport source (output valid, data_out, status, length, last, input ready);
  modport sink (input valid, data_out, status, length, last, output ready);
endinterface

// ===== hdl/pidl_ctrl.sv =====
module pidl_ctrl import pidl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pidl_stat_t stat_i,
  output pidl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StateIdle: begin
        if (in_valid_i) state_d = StateExec;
      end
      StateExec: begin
        // A dump of a non-empty list streams; everything else gives one word.
        if (stat_i.is_dump && !stat_i.count_zero) begin
          state_d = StateDump;
        end else if (stat_i.out_free) begin
          state_d = StateIdle;
        end
      end
      StateDump: begin
        if (stat_i.out_free && stat_i.dump_last) state_d = StateIdle;
      end
      default: state_d = StateIdle;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      StateIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      StateExec: begin
        cmd_o.commit = stat_i.out_free && !(stat_i.is_dump && !stat_i.count_zero);
      end
      StateDump: begin
        cmd_o.load_dump = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/pidl_dp.sv =====
module pidl_dp import pidl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  pidl_in_if.sink           in_i,
  pidl_out_if.source        out_o,
  input  pidl_cmd_t         cmd_i,
  output pidl_stat_t        stat_o
);

  logic [ActW-1:0]          act_q;
  logic [PosW-1:0]          pos_q;
  logic [DataWidth-1:0]     val_q;
  logic [CountW-1:0]        count_q, count_d;
  logic [DataWidth-1:0]     elem_q [Depth];
  logic [DataWidth-1:0]     elem_d [Depth];
  logic [IdxW-1:0]          idx_q;

  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q;
  logic [StatW-1:0]         out_stat_q;
  logic [CountW-1:0]        out_len_q;
  logic                     out_last_q;

  logic [PosW-1:0]          tgt;
  logic [PosW-1:0]          tgt_m1;
  logic [IdxW-1:0]          k;
  logic [CountW-1:0]        count_inc;
  logic [CountW-1:0]        idx_inc;
  logic                     op_ins;
  logic                     op_rem;
  status_e                  st;
  logic                     do_ins;
  logic                     do_rem;
  logic                     out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= in_i.action;
      pos_q <= in_i.position;
      val_q <= DataWidth'(in_i.value);
    end
  end

  assign count_inc = count_q + CountW'(1);

  always_comb begin
    op_ins = 1'b0;
    op_rem = 1'b0;
    tgt    = pos_q;
    case (act_q)
      ActInsFront: begin
        op_ins = 1'b1;
        tgt    = PosW'(1);
      end
      ActInsPos: op_ins = 1'b1;
      ActAppend: begin
        op_ins = 1'b1;
        tgt    = PosW'(count_inc);
      end
      ActRemove: op_rem = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    st = StatBad;
    if (op_ins) begin
      // Fullness is checked before the position.
      if (count_q >= CountW'(Depth)) begin
        st = StatFull;
      end else if (tgt == '0 || CountW'(tgt) > count_inc) begin
        st = StatBad;
      end else begin
        st = StatOk;
      end
    end else if (op_rem) begin
      if (count_q == '0 || tgt == '0 || CountW'(tgt) > count_q) begin
        st = StatBad;
      end else begin
        st = StatOk;
      end
    end
  end

  assign tgt_m1 = tgt - PosW'(1);
  assign k      = tgt_m1[IdxW-1:0];
  assign do_ins = cmd_i.commit && op_ins && (st == StatOk);
  assign do_rem = cmd_i.commit && op_rem && (st == StatOk);

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_inc;
    if (do_rem) count_d = count_q - CountW'(1);
  end

  // Insert shifts the tail back by one word, remove pulls it forward.
  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      elem_d[j] = elem_q[j];
      if (do_ins) begin
        if (IdxW'(j) == k) begin
          elem_d[j] = val_q;
        end else if (j > 0) begin
          if (IdxW'(j) > k) elem_d[j] = elem_q[j-1];
        end
      end else if (do_rem) begin
        if (j < Depth - 1) begin
          if (IdxW'(j) >= k) elem_d[j] = elem_q[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < Depth; j++) begin
      elem_q[j] <= elem_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign idx_inc = CountW'(idx_q) + CountW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.latch) begin
      idx_q <= '0;
    end else if (cmd_i.load_dump) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.load_dump) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= '0;
      out_stat_q <= st;
      out_len_q  <= count_d;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_dump) begin
      out_data_q <= OutDataW'(elem_q[idx_q]);
      out_stat_q <= StatOk;
      out_len_q  <= count_q;
      out_last_q <= (idx_inc == count_q);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;
  assign out_o.status   = out_stat_q;
  assign out_o.length   = out_len_q;
  assign out_o.last     = out_last_q;

  assign stat_o.is_dump    = (act_q == ActDump);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.out_free   = out_free;
  assign stat_o.dump_last  = (idx_inc == count_q);

endmodule

// ===== hdl/positional_insert_delete_list.sv =====
// An accepted word is registered and decoded; its result word then waits for a free output
// register. Insert, append, remove and failing actions give one result word each; a dump of
// a non-empty list streams one element word per cycle while the output does not stall.
// The rate is set by the controller, which works on one input word at a time.
// Reset clears the element count and the output valid; element storage is not cleared.
module positional_insert_delete_list import pidl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pidl_in_if.sink    in_i,
  pidl_out_if.source out_o
);

  pidl_cmd_t  cmd;
  pidl_stat_t stat;

  pidl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pidl_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // Only one word is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while a word is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.length <= CountW'(Depth))
    else $error("list length beyond depth");

  // Every failing action gives a single word with zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != StatOk |-> out_o.last && out_o.data_out == '0)
    else $error("failure word not final or carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !cmd.load_dump && stat.out_free)
    else $error("result loaded while the output register is busy");

endmodule
